@@ design/gslc_pkg.sv @@
// Shared types and constants for the surface layout calculator.
// Holds tile/status/dimension codes, the descriptor record passed front to
// back, and the result record. No dependencies.
package gslc_pkg;

  localparam int LEVEL_LIMIT_DEF = 14;
  localparam int LVL_W           = 4;
  localparam int IN_TDATA_W      = 112;
  localparam int OUT_TDATA_W     = 184;
  localparam int QUEUE_DEPTH     = 2;

  // tile modes
  localparam logic [4:0] TILE_DEFAULT     = 5'd0;
  localparam logic [4:0] TILE_LIN_ALIGNED = 5'd1;
  localparam logic [4:0] TILE_1D_THIN     = 5'd2;
  localparam logic [4:0] TILE_1D_THICK    = 5'd3;
  localparam logic [4:0] TILE_2D_THIN     = 5'd4;
  localparam logic [4:0] TILE_2D_THICK    = 5'd7;
  localparam logic [4:0] TILE_LIN_SPECIAL = 5'd16;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_AA   = 3'd1;
  localparam logic [2:0] ST_BAD_DIM  = 3'd2;
  localparam logic [2:0] ST_BAD_TILE = 3'd3;
  localparam logic [2:0] ST_BAD_FMT  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  // dimensions
  localparam logic [2:0] DIM_1D       = 3'd0;
  localparam logic [2:0] DIM_2D       = 3'd1;
  localparam logic [2:0] DIM_3D       = 3'd2;
  localparam logic [2:0] DIM_CUBE     = 3'd3;
  localparam logic [2:0] DIM_1D_ARRAY = 3'd4;
  localparam logic [2:0] DIM_2D_ARRAY = 3'd5;

  localparam logic [31:0] SWZ_KEEP_MASK  = 32'hFF00FFFF;
  localparam logic [31:0] SWZ_TILED_MARK = 32'h000D0000;

  typedef struct packed {
    logic [2:0]       status;
    logic [2:0]       dim;
    logic [2:0]       elem_log;   // log2 of element bits
    logic             bc;         // block compressed
    logic             changed;    // tile promoted from default
    logic [4:0]       tile;
    logic [31:0]      swz;
    logic [13:0]      width;
    logic [13:0]      height;
    logic [10:0]      depth;
    logic [LVL_W-1:0] levels;
  } desc_t;

  typedef struct packed {
    logic             kind;
    logic [2:0]       status;
    logic [4:0]       final_tile;
    logic [31:0]      swizzle_out;
    logic [31:0]      image_size;
    logic [31:0]      chain_size;
    logic [16:0]      base_alignment;
    logic [15:0]      row_pitch;
    logic [LVL_W-1:0] level_count;
    logic [LVL_W-1:0] level_number;
    logic [31:0]      level_offset;
    logic             last;
  } result_t;

endpackage

@@ design/gslc_front.sv @@
// Front end: accepts descriptor transactions, validates and classifies them.
// Depends on gslc_pkg; feeds gslc_queue.
module gslc_front #(
  parameter int LEVEL_LIMIT = gslc_pkg::LEVEL_LIMIT_DEF
) (
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gslc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              q_full,
  output logic                              q_push,
  output gslc_pkg::desc_t                   q_desc
);

  logic [2:0]  dim;
  logic [11:0] fmt;
  logic [7:0]  use_f;
  logic [1:0]  aa;
  logic [4:0]  req;
  logic [13:0] w_in;
  logic [13:0] h_in;
  logic [10:0] d_in;
  logic [3:0]  rl;
  logic [31:0] swz_in;
  logic [3:0]  ecode;
  logic [13:0] maxd;
  logic [gslc_pkg::LVL_W-1:0] nmax;
  logic [gslc_pkg::LVL_W-1:0] levels;
  logic [4:0]  tm;
  logic        changed;
  logic [31:0] swz;

  // {valid, log2 of element bits}
  function automatic logic [3:0] elem_code(logic [5:0] c);
    logic [3:0] r;
    case (c) inside
      [6'h01:6'h03]:               r = 4'b1011;
      [6'h05:6'h0C]:               r = 4'b1100;
      [6'h0D:6'h1B]:               r = 4'b1101;
      [6'h1C:6'h20], 6'h31, 6'h34: r = 4'b1110;
      6'h22, 6'h23, 6'h32, 6'h33, 6'h35: r = 4'b1111;
      default:                     r = 4'b0000;
    endcase
    return r;
  endfunction

  assign dim    = in_tdata[2:0];
  assign fmt    = in_tdata[14:3];
  assign use_f  = in_tdata[22:15];
  assign aa     = in_tdata[24:23];
  assign req    = in_tdata[29:25];
  assign w_in   = in_tdata[43:30];
  assign h_in   = in_tdata[57:44];
  assign d_in   = in_tdata[68:58];
  assign rl     = in_tdata[72:69];
  assign swz_in = in_tdata[104:73];

  assign ecode     = elem_code(fmt[5:0]);
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    // largest extent, then its bit length caps the chain
    maxd = (w_in == 14'd0) ? 14'd1 : w_in;
    if (dim != gslc_pkg::DIM_1D && dim != gslc_pkg::DIM_1D_ARRAY && h_in > maxd) begin
      maxd = h_in;
    end
    if (dim == gslc_pkg::DIM_3D && {3'b0, d_in} > maxd) begin
      maxd = {3'b0, d_in};
    end
    nmax = '0;
    for (int i = 0; i < 14; i++) begin
      if (maxd[i]) nmax = gslc_pkg::LVL_W'(i + 1);
    end
    levels = (rl == 4'd0) ? 4'd1 : rl;
    if (levels > nmax) levels = nmax;
    if (int'(levels) > LEVEL_LIMIT) levels = gslc_pkg::LVL_W'(LEVEL_LIMIT);

    tm      = req;
    changed = 1'b0;
    if (req == gslc_pkg::TILE_DEFAULT) begin
      tm = gslc_pkg::TILE_LIN_ALIGNED;
      if (dim != gslc_pkg::DIM_1D || use_f[2]) begin
        tm = (dim != gslc_pkg::DIM_3D || use_f[1]) ? gslc_pkg::TILE_2D_THIN
                                                   : gslc_pkg::TILE_2D_THICK;
        changed = 1'b1;
      end
    end
    swz = swz_in & gslc_pkg::SWZ_KEEP_MASK;
    if (tm >= gslc_pkg::TILE_2D_THIN && tm != gslc_pkg::TILE_LIN_SPECIAL) begin
      swz = swz | gslc_pkg::SWZ_TILED_MARK;
    end

    q_desc.status = gslc_pkg::ST_OK;
    if (aa != 2'd0) begin
      q_desc.status = gslc_pkg::ST_BAD_AA;
    end else if (dim > gslc_pkg::DIM_2D_ARRAY) begin
      q_desc.status = gslc_pkg::ST_BAD_DIM;
    end else if (req != gslc_pkg::TILE_DEFAULT && req != gslc_pkg::TILE_1D_THIN &&
                 req != gslc_pkg::TILE_2D_THIN && req != gslc_pkg::TILE_LIN_SPECIAL) begin
      q_desc.status = gslc_pkg::ST_BAD_TILE;
    end else if (!ecode[3]) begin
      q_desc.status = gslc_pkg::ST_BAD_FMT;
    end
    q_desc.dim      = dim;
    q_desc.elem_log = ecode[2:0];
    q_desc.bc       = (fmt[5:0] >= 6'h31) && (fmt[5:0] <= 6'h35);
    q_desc.changed  = changed;
    q_desc.tile     = tm;
    q_desc.swz      = swz;
    q_desc.width    = w_in;
    q_desc.height   = h_in;
    q_desc.depth    = d_in;
    q_desc.levels   = levels;
  end

endmodule

@@ design/gslc_queue.sv @@
// Small descriptor queue decoupling the front end from the layout walker.
// Depends on gslc_pkg (desc_t, QUEUE_DEPTH).
module gslc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gslc_pkg::desc_t din,
  output logic            full,
  input  logic            pop,
  output gslc_pkg::desc_t dout,
  output logic            empty
);

  localparam int PW = $clog2(gslc_pkg::QUEUE_DEPTH);

  gslc_pkg::desc_t mem_r [gslc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     count_r, count_nxt;

  assign full  = (count_r == (PW+1)'(gslc_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

@@ design/gslc_back.sv @@
// Back end: per-level geometry, size multiply, mip walk and result register.
// Depends on gslc_pkg; pops descriptors from gslc_queue.
module gslc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  gslc_pkg::desc_t   q_desc,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output gslc_pkg::result_t out_rec
);

  typedef enum logic [2:0] {S_IDLE, S_DIMS, S_MUL1, S_MUL2, S_LEVEL, S_FINAL} state_t;

  typedef struct packed {
    logic [8:0]  pa;
    logic [4:0]  ha;
    logic [14:0] ba;
    logic        thick;
  } geom_t;

  function automatic geom_t tile_geom(logic [4:0] tm, logic [2:0] b);
    geom_t g;
    g.thick = (tm == gslc_pkg::TILE_1D_THICK) || (tm == gslc_pkg::TILE_2D_THICK);
    case (tm) inside
      gslc_pkg::TILE_1D_THIN, gslc_pkg::TILE_1D_THICK: begin
        g.ha = 5'd8;
        g.ba = 15'd256;
        if (g.thick) g.pa = 9'd8;
        else if (b == 3'd3) g.pa = 9'd32;
        else if (b == 3'd4) g.pa = 9'd16;
        else g.pa = 9'd8;
      end
      gslc_pkg::TILE_2D_THIN, gslc_pkg::TILE_2D_THICK: begin
        g.ha = 5'd16;
        if (g.thick) begin
          g.pa = 9'd32;
          if (b == 3'd3) g.ba = 15'd2048;
          else if (b == 3'd4) g.ba = 15'd4096;
          else if (b == 3'd5) g.ba = 15'd8192;
          else g.ba = 15'd16384;
        end else begin
          if (b == 3'd3) g.pa = 9'd128;
          else if (b == 3'd4) g.pa = 9'd64;
          else g.pa = 9'd32;
          if (b == 3'd6) g.ba = 15'd4096;
          else if (b == 3'd7) g.ba = 15'd8192;
          else g.ba = 15'd2048;
        end
      end
      gslc_pkg::TILE_LIN_SPECIAL: begin
        g.pa = 9'd1;
        g.ha = 5'd1;
        g.ba = 15'd1;
      end
      default: begin
        g.ha = 5'd1;
        g.ba = 15'd256;
        if (b == 3'd3) g.pa = 9'd256;
        else if (b == 3'd4) g.pa = 9'd128;
        else g.pa = 9'd64;
      end
    endcase
    return g;
  endfunction

  state_t            state_r, state_nxt;
  gslc_pkg::desc_t   d_r, d_nxt;
  logic [4:0]        tm_r, tm_nxt;
  logic [31:0]       swz_r, swz_nxt;
  logic [3:0]        lv_r, lv_nxt;
  logic              spad_r, spad_nxt;
  logic [14:0]       pitch_r, pitch_nxt;
  logic [14:0]       hp_r, hp_nxt;
  logic [11:0]       sl_r, sl_nxt;
  logic [14:0]       ba_r, ba_nxt;
  logic [29:0]       m1_r, m1_nxt;
  logic [46:0]       size_r, size_nxt;
  logic [31:0]       info_size_r, info_size_nxt;
  logic [14:0]       info_ba_r, info_ba_nxt;
  logic [14:0]       info_pitch_r, info_pitch_nxt;
  logic [4:0]        info_tile_r, info_tile_nxt;
  logic [31:0]       prev_r, prev_nxt;
  logic [31:0]       base_r, base_nxt;
  logic [31:0]       last_off_r, last_off_nxt;
  logic              out_valid_r, out_valid_nxt;
  gslc_pkg::result_t out_rec_r, out_rec_nxt;

  geom_t       g;
  logic        out_free;
  logic [13:0] w1, h1, d_sh, s_l;
  logic [14:0] wb, hb, hl;
  logic        is_2d, demote;
  logic [14:0] pad_al;
  logic [16:0] pad;
  logic [33:0] off;
  logic [32:0] mip_sum;
  logic [41:0] prod;
  gslc_pkg::result_t fail_rec;

  assign q_pop     = (state_r == S_IDLE) && !q_empty &&
                     (q_desc.status == gslc_pkg::ST_OK || out_free);
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

  always_comb begin
    g     = tile_geom(tm_r, d_r.elem_log);
    is_2d = (tm_r == gslc_pkg::TILE_2D_THIN) || (tm_r == gslc_pkg::TILE_2D_THICK);

    // level extents
    w1   = ((d_r.width >> lv_r) == 14'd0) ? 14'd1 : (d_r.width >> lv_r);
    h1   = ((d_r.height >> lv_r) == 14'd0) ? 14'd1 : (d_r.height >> lv_r);
    d_sh = {3'b0, d_r.depth} >> lv_r;
    wb   = d_r.bc ? ((15'(w1) + 15'd3) >> 2) : 15'(w1);
    hb   = d_r.bc ? ((15'(h1) + 15'd3) >> 2) : 15'(h1);
    case (d_r.dim)
      gslc_pkg::DIM_2D: begin
        hl = hb; s_l = 14'd1;
      end
      gslc_pkg::DIM_3D: begin
        hl = hb; s_l = (d_sh == 14'd0) ? 14'd1 : d_sh;
      end
      gslc_pkg::DIM_CUBE: begin
        hl = hb; s_l = (d_r.depth < 11'd6) ? 14'd6 : {3'b0, d_r.depth};
      end
      gslc_pkg::DIM_1D_ARRAY: begin
        hl = 15'd1; s_l = (d_r.depth == 11'd0) ? 14'd1 : {3'b0, d_r.depth};
      end
      gslc_pkg::DIM_2D_ARRAY: begin
        hl = hb; s_l = (d_r.depth == 11'd0) ? 14'd1 : {3'b0, d_r.depth};
      end
      default: begin
        hl = 15'd1; s_l = 14'd1;
      end
    endcase

    // base level: promoted tile falls back when smaller than one tile;
    // walk: a 2D level narrower or shorter than a tile goes 1D
    if (lv_r == 4'd0) begin
      demote = d_r.changed && is_2d && ({1'b0, d_r.width} < {6'b0, g.pa}) &&
               ({1'b0, d_r.height} < {10'b0, g.ha});
    end else begin
      demote = is_2d && ((wb < {6'b0, g.pa}) || (hb < {10'b0, g.ha}));
    end

    pad_al  = (~prev_r[14:0] + 15'd1) & (ba_r - 15'd1);
    pad     = 17'(pad_al) + (spad_r ? 17'(swz_r[15:0]) : 17'd0);
    off     = 34'(pad) + 34'(prev_r) + 34'(base_r);
    mip_sum = 33'(prev_r) + 33'(last_off_r);
    prod    = 42'(m1_r) * 42'(sl_r);

    fail_rec        = '0;
    fail_rec.kind   = 1'b1;
    fail_rec.last   = 1'b1;
    fail_rec.status = gslc_pkg::ST_OVERFLOW;

    state_nxt      = state_r;
    d_nxt          = d_r;
    tm_nxt         = tm_r;
    swz_nxt        = swz_r;
    lv_nxt         = lv_r;
    spad_nxt       = spad_r;
    pitch_nxt      = pitch_r;
    hp_nxt         = hp_r;
    sl_nxt         = sl_r;
    ba_nxt         = ba_r;
    m1_nxt         = m1_r;
    size_nxt       = size_r;
    info_size_nxt  = info_size_r;
    info_ba_nxt    = info_ba_r;
    info_pitch_nxt = info_pitch_r;
    info_tile_nxt  = info_tile_r;
    prev_nxt       = prev_r;
    base_nxt       = base_r;
    last_off_nxt   = last_off_r;
    out_rec_nxt    = out_rec_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          d_nxt    = q_desc;
          tm_nxt   = q_desc.tile;
          swz_nxt  = q_desc.swz;
          lv_nxt   = 4'd0;
          spad_nxt = 1'b0;
          base_nxt = '0;
          if (q_desc.status != gslc_pkg::ST_OK) begin
            out_rec_nxt        = fail_rec;
            out_rec_nxt.status = q_desc.status;
            out_valid_nxt      = 1'b1;
          end else begin
            state_nxt = S_DIMS;
          end
        end
      end
      S_DIMS: begin
        if (demote) begin
          tm_nxt = g.thick ? gslc_pkg::TILE_1D_THICK : gslc_pkg::TILE_1D_THIN;
          if (lv_r == 4'd0) begin
            swz_nxt = swz_r & gslc_pkg::SWZ_KEEP_MASK;
          end else begin
            swz_nxt  = (swz_r & gslc_pkg::SWZ_KEEP_MASK) | {8'b0, 4'b0, lv_r, 16'b0};
            spad_nxt = (lv_r > 4'd1);
          end
        end else begin
          if (tm_r == gslc_pkg::TILE_LIN_SPECIAL) begin
            pitch_nxt = wb;
            hp_nxt    = hl;
          end else begin
            pitch_nxt = (wb + 15'(g.pa) - 15'd1) & ~(15'(g.pa) - 15'd1);
            hp_nxt    = (hl + 15'(g.ha) - 15'd1) & ~(15'(g.ha) - 15'd1);
          end
          sl_nxt    = g.thick ? ((12'(s_l) + 12'd3) & ~12'd3) : 12'(s_l);
          ba_nxt    = g.ba;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        m1_nxt    = 30'(hp_r) * 30'(pitch_r);
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        size_nxt  = 47'(prod) << (d_r.elem_log - 3'd3);
        state_nxt = S_LEVEL;
      end
      S_LEVEL: begin
        if (lv_r == 4'd0) begin
          if (|size_r[46:32]) begin
            if (out_free) begin
              out_rec_nxt   = fail_rec;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end else begin
            info_size_nxt  = size_r[31:0];
            info_ba_nxt    = ba_r;
            info_pitch_nxt = pitch_r;
            info_tile_nxt  = tm_r;
            prev_nxt       = size_r[31:0];
            if (d_r.levels > 4'd1) begin
              lv_nxt    = 4'd1;
              state_nxt = S_DIMS;
            end else begin
              state_nxt = S_FINAL;
            end
          end
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          if ((|off[33:32]) || (|size_r[46:32])) begin
            out_rec_nxt = fail_rec;
            state_nxt   = S_IDLE;
          end else begin
            out_rec_nxt              = '0;
            out_rec_nxt.level_number = lv_r;
            out_rec_nxt.level_offset = off[31:0];
            prev_nxt                 = size_r[31:0];
            last_off_nxt             = off[31:0];
            // level 1 is measured from the image, later ones from mip start
            base_nxt                 = (lv_r == 4'd1) ? 32'd0 : off[31:0];
            spad_nxt                 = 1'b0;
            if (lv_r + 4'd1 < d_r.levels) begin
              lv_nxt    = lv_r + 4'd1;
              state_nxt = S_DIMS;
            end else begin
              state_nxt = S_FINAL;
            end
          end
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (d_r.levels > 4'd1 && mip_sum[32]) begin
            out_rec_nxt = fail_rec;
          end else begin
            out_rec_nxt                = '0;
            out_rec_nxt.kind           = 1'b1;
            out_rec_nxt.last           = 1'b1;
            out_rec_nxt.status         = gslc_pkg::ST_OK;
            out_rec_nxt.final_tile     = info_tile_r;
            out_rec_nxt.swizzle_out    = swz_r;
            out_rec_nxt.image_size     = info_size_r;
            out_rec_nxt.chain_size     = (d_r.levels > 4'd1) ? mip_sum[31:0] : 32'd0;
            out_rec_nxt.base_alignment = 17'(info_ba_r);
            out_rec_nxt.row_pitch      = 16'(info_pitch_r);
            out_rec_nxt.level_count    = d_r.levels;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    d_r          <= d_nxt;
    tm_r         <= tm_nxt;
    swz_r        <= swz_nxt;
    lv_r         <= lv_nxt;
    spad_r       <= spad_nxt;
    pitch_r      <= pitch_nxt;
    hp_r         <= hp_nxt;
    sl_r         <= sl_nxt;
    ba_r         <= ba_nxt;
    m1_r         <= m1_nxt;
    size_r       <= size_nxt;
    info_size_r  <= info_size_nxt;
    info_ba_r    <= info_ba_nxt;
    info_pitch_r <= info_pitch_nxt;
    info_tile_r  <= info_tile_nxt;
    prev_r       <= prev_nxt;
    base_r       <= base_nxt;
    last_off_r   <= last_off_nxt;
    out_rec_r    <= out_rec_nxt;
  end

endmodule

@@ design/gpu_surface_layout_calculator.sv @@
// Top level of the tiled surface layout calculator.
// Depends on gslc_pkg, gslc_front, gslc_queue and gslc_back.
//
// Each input transaction is one texture surface descriptor. The block answers
// with one offset transaction per mip level 1..level_count-1 (tuser = 0) and
// then a final layout transaction (tuser = 1, tlast = 1). A rejected
// descriptor (bad AA, dimension, tile mode or format) gives only the final
// transaction with its status. On overflow a final transaction with status
// overflow follows whatever offsets were already sent; the consumer must
// drop those offsets. In the back end a rejected descriptor is answered
// from the pop itself; an accepted one goes through the pop, then geometry,
// two multiply steps and the level step for each level, then the final
// record, with one more geometry step when the tile is demoted, which
// happens at most once per descriptor, plus any waiting on out_tready.
// The order is set by the back-end sequencer, which runs the per-level
// geometry and then the size product as two registered multiply steps.
// A two-entry descriptor queue lets the input side keep accepting while
// the back end works or waits on the result register.

module gpu_surface_layout_calculator #(
  parameter int LEVEL_LIMIT = gslc_pkg::LEVEL_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] dimension, [14:3] surface_format, [22:15] use_flags,
  // [24:23] sample_mode, [29:25] requested_tile, [43:30] surf_width,
  // [57:44] surf_height, [68:58] surf_depth, [72:69] requested_levels,
  // [104:73] swizzle_in, rest zero
  input  logic [gslc_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] status, [7:3] final_tile, [39:8] swizzle_out, [71:40] image_size,
  // [103:72] chain size, [120:104] base_alignment, [136:121] row_pitch,
  // [140:137] level_count, [144:141] level_number, [176:145] level_offset,
  // rest zero
  output logic [gslc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] kind: 0 level offset, 1 final layout
  output logic [0:0]                         out_tuser,
  output logic                               out_tlast
);

  gslc_pkg::desc_t   push_desc;
  gslc_pkg::desc_t   head_desc;
  gslc_pkg::result_t rec;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;

  gslc_front #(
    .LEVEL_LIMIT (LEVEL_LIMIT)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  gslc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_desc),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (head_desc),
    .empty (q_empty)
  );

  gslc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_desc    (head_desc),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (rec)
  );

  // result record onto the stream
  assign out_tdata = {7'b0, rec.level_offset, rec.level_number, rec.level_count,
                      rec.row_pitch, rec.base_alignment, rec.chain_size,
                      rec.image_size, rec.swizzle_out, rec.final_tile, rec.status};
  assign out_tuser = rec.kind;
  assign out_tlast = rec.last;

endmodule

@@ test/gpu_surface_layout_calculator_tb.sv @@
// Testbench for gpu_surface_layout_calculator: a clocked driver sends surface
// descriptors, a clocked monitor checks every layout transaction against an
// in-bench layout predictor. Depends on gslc_pkg and the RTL top level.
`timescale 1ns / 1ps

module gpu_surface_layout_calculator_tb;

  localparam int N_RANDOM = 360;
  localparam int IN_W     = gslc_pkg::IN_TDATA_W;
  localparam int OUT_W    = gslc_pkg::OUT_TDATA_W;

  // sample format codes, one per element class, and three invalid ones
  localparam logic [11:0] FMT_8B     = 12'h001;
  localparam logic [11:0] FMT_16B    = 12'h005;
  localparam logic [11:0] FMT_32B    = 12'h01A;
  localparam logic [11:0] FMT_64B    = 12'h020;
  localparam logic [11:0] FMT_128B   = 12'h022;
  localparam logic [11:0] FMT_BC64   = 12'h031;
  localparam logic [11:0] FMT_BC128  = 12'h035;
  localparam logic [11:0] FMT_HOLE   = 12'h004;
  localparam logic [11:0] FMT_ZERO   = 12'h000;
  localparam logic [11:0] FMT_TOP    = 12'hFFF;

  typedef struct {
    logic [2:0]  dim;
    logic [11:0] fmt;
    logic [7:0]  use_f;
    logic [1:0]  aa;
    logic [4:0]  tile;
    logic [13:0] w;
    logic [13:0] h;
    logic [10:0] d;
    logic [3:0]  lvls;
    logic [31:0] swz;
    bit          drain;   // wait for all results before sending
    int          ph;      // idling phase
  } surf_t;

  typedef struct {
    int unsigned       pitch;
    int unsigned       palign;
    int unsigned       halign;
    int unsigned       balign;
    longint unsigned   size;
  } geom_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic out_tlast;

  surf_t             pending_q[$];
  gslc_pkg::result_t layout_q[$];     // expected layout transactions, oldest first
  surf_t             cur_surf;
  int                cur_ph = 0;
  int                n_total = 0;
  int                n_sent = 0;
  int                n_err = 0;

  always #5 clk = ~clk;

  gpu_surface_layout_calculator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned umax(int unsigned a, int unsigned b);
    return a > b ? a : b;
  endfunction

  function automatic int unsigned aup(int unsigned v, int unsigned a);
    return (v + a - 1) & ~(a - 1);
  endfunction

  function automatic int unsigned elem_bits(logic [11:0] f);
    int unsigned c;
    c = f & 12'h03F;
    if (c >= 1 && c <= 3) return 8;
    if (c >= 5 && c <= 12) return 16;
    if (c >= 13 && c <= 27) return 32;
    if (c >= 28 && c <= 32) return 64;
    if (c == 34 || c == 35) return 128;
    if (c == 49 || c == 52) return 64;
    if (c == 50 || c == 51 || c == 53) return 128;
    return 0;
  endfunction

  function automatic geom_t tiled_geom(logic [4:0] tm, int unsigned w, int unsigned h,
                                       int unsigned s, int unsigned bpp);
    geom_t g;
    int unsigned thick, hp, sl, mtb, split;
    thick = (tm == gslc_pkg::TILE_1D_THICK || tm == gslc_pkg::TILE_2D_THICK) ? 4 : 1;
    if (tm == gslc_pkg::TILE_1D_THIN || tm == gslc_pkg::TILE_1D_THICK) begin
      g.balign = 256;
      g.palign = umax(8, 256 / bpp / thick);
      g.halign = 8;
    end else if (tm == gslc_pkg::TILE_2D_THIN || tm == gslc_pkg::TILE_2D_THICK) begin
      g.palign = umax(32, 32 * (256 / bpp / (8 * thick)));
      g.halign = 16;
      if (thick == 1)
        g.balign = umax(bpp * 16 * 32 / 8, 16 * bpp * g.palign / 8);
      else
        g.balign = umax(256, 4 * 16 * bpp * g.palign / 8);
      mtb = thick * bpp * 64 / 8;
      split = (mtb >= 2048) ? mtb / 2048 : 1;
      g.balign = g.balign / split;
    end else begin
      g.balign = 256;
      g.palign = umax(64, 2048 / bpp);
      g.halign = 1;
    end
    g.pitch = aup(w, g.palign);
    hp = aup(h, g.halign);
    sl = (thick > 1) ? aup(s, thick) : s;
    g.size = longint'(hp) * g.pitch * sl * bpp / 8;
    return g;
  endfunction

  // geometry of one mip level; bc folds 4x4 blocks into one element
  function automatic geom_t level_geom(logic [4:0] tm, int unsigned lv, surf_t sd,
                                       int unsigned bpp, bit bc);
    geom_t g;
    int unsigned w, h, s, hl;
    w = umax(1, sd.w >> lv);
    h = 1;
    s = 1;
    hl = umax(1, sd.h >> lv);
    case (sd.dim)
      gslc_pkg::DIM_2D:       h = hl;
      gslc_pkg::DIM_3D:       begin h = hl; s = umax(1, sd.d >> lv); end
      gslc_pkg::DIM_CUBE:     begin h = hl; s = umax(6, sd.d); end
      gslc_pkg::DIM_1D_ARRAY: s = umax(1, sd.d);
      gslc_pkg::DIM_2D_ARRAY: begin h = hl; s = umax(1, sd.d); end
      default: ;
    endcase
    if (bc) begin
      w = 1 + (w - 1) / 4;
      h = 1 + (h - 1) / 4;
    end
    if (tm != gslc_pkg::TILE_LIN_SPECIAL) return tiled_geom(tm, w, h, s, bpp);
    g.pitch = w;
    g.palign = 1;
    g.halign = 1;
    g.balign = 1;
    g.size = longint'(w) * h * s * (bpp / 8);
    return g;
  endfunction

  function automatic gslc_pkg::result_t final_rec(logic [2:0] st);
    gslc_pkg::result_t r;
    r = '0;
    r.kind = 1'b1;
    r.last = 1'b1;
    r.status = st;
    return r;
  endfunction

  // works out every layout transaction one descriptor causes
  function automatic void predict_layout(surf_t sd);
    int unsigned bpp, maxd, nmax, levels, lv, mip, off0, w, h;
    int unsigned offs[gslc_pkg::LEVEL_LIMIT_DEF];
    logic [4:0] tm, last_tm;
    logic [31:0] swz;
    longint unsigned prev, pad, off, m;
    bit bc, changed;
    geom_t info, li;
    gslc_pkg::result_t r;
    changed = 0;
    nmax = 0;
    mip = 0;
    off0 = 0;
    if (sd.aa != 0) begin
      layout_q.push_back(final_rec(gslc_pkg::ST_BAD_AA));
      return;
    end
    if (sd.dim > gslc_pkg::DIM_2D_ARRAY) begin
      layout_q.push_back(final_rec(gslc_pkg::ST_BAD_DIM));
      return;
    end
    if (sd.tile != gslc_pkg::TILE_DEFAULT && sd.tile != gslc_pkg::TILE_1D_THIN &&
        sd.tile != gslc_pkg::TILE_2D_THIN && sd.tile != gslc_pkg::TILE_LIN_SPECIAL) begin
      layout_q.push_back(final_rec(gslc_pkg::ST_BAD_TILE));
      return;
    end
    bpp = elem_bits(sd.fmt);
    if (bpp == 0) begin
      layout_q.push_back(final_rec(gslc_pkg::ST_BAD_FMT));
      return;
    end
    bc = (sd.fmt[5:0] >= 6'h31 && sd.fmt[5:0] <= 6'h35);

    maxd = umax(1, sd.w);
    if (sd.dim != gslc_pkg::DIM_1D && sd.dim != gslc_pkg::DIM_1D_ARRAY)
      maxd = umax(maxd, umax(1, sd.h));
    if (sd.dim == gslc_pkg::DIM_3D) maxd = umax(maxd, umax(1, sd.d));
    while (maxd != 0) begin
      nmax++;
      maxd >>= 1;
    end
    levels = umax(sd.lvls, 1);
    if (levels > nmax) levels = nmax;
    if (levels > gslc_pkg::LEVEL_LIMIT_DEF) levels = gslc_pkg::LEVEL_LIMIT_DEF;

    tm = sd.tile;
    if (tm == gslc_pkg::TILE_DEFAULT) begin
      tm = gslc_pkg::TILE_LIN_ALIGNED;
      if (sd.dim != gslc_pkg::DIM_1D || sd.use_f[2]) begin
        tm = (sd.dim != gslc_pkg::DIM_3D || sd.use_f[1]) ? gslc_pkg::TILE_2D_THIN
                                                         : gslc_pkg::TILE_2D_THICK;
        changed = 1;
      end
    end
    swz = sd.swz & gslc_pkg::SWZ_KEEP_MASK;
    if (tm >= gslc_pkg::TILE_2D_THIN && tm != gslc_pkg::TILE_LIN_SPECIAL)
      swz |= gslc_pkg::SWZ_TILED_MARK;

    // promoted surface smaller than one macro tile drops to micro tiling
    info = level_geom(tm, 0, sd, bpp, bc);
    if (changed && sd.w < info.palign && sd.h < info.halign) begin
      tm = (tm == gslc_pkg::TILE_2D_THICK) ? gslc_pkg::TILE_1D_THICK : gslc_pkg::TILE_1D_THIN;
      info = level_geom(tm, 0, sd, bpp, bc);
      swz &= gslc_pkg::SWZ_KEEP_MASK;
    end
    if (info.size > 64'hFFFF_FFFF) begin
      layout_q.push_back(final_rec(gslc_pkg::ST_OVERFLOW));
      return;
    end

    foreach (offs[i]) offs[i] = 0;
    last_tm = tm;
    prev = info.size;
    for (lv = 1; lv < levels; lv++) begin
      pad = 0;
      li = level_geom(last_tm, lv, sd, bpp, bc);
      if (last_tm >= gslc_pkg::TILE_2D_THIN && last_tm != gslc_pkg::TILE_LIN_SPECIAL) begin
        w = umax(1, sd.w >> lv);
        h = umax(1, sd.h >> lv);
        if (bc) begin
          w = 1 + (w - 1) / 4;
          h = 1 + (h - 1) / 4;
        end
        // per-level demotion: level number lands in the swizzle
        if (w < li.palign || h < li.halign) begin
          last_tm = (last_tm == gslc_pkg::TILE_2D_THICK) ? gslc_pkg::TILE_1D_THICK
                                                         : gslc_pkg::TILE_1D_THIN;
          li = level_geom(last_tm, lv, sd, bpp, bc);
          swz = (lv << 16) | (swz & gslc_pkg::SWZ_KEEP_MASK);
          if (lv > 1) pad = swz[15:0];
        end
      end
      pad += (li.balign - (prev % li.balign)) % li.balign;
      off = pad + prev + (lv > 1 ? offs[lv - 2] : 0);
      if (off > 64'hFFFF_FFFF || li.size > 64'hFFFF_FFFF) begin
        layout_q.push_back(final_rec(gslc_pkg::ST_OVERFLOW));
        return;
      end
      if (lv == 1) off0 = off;
      else offs[lv - 1] = off;
      r = '0;
      r.level_number = lv;
      r.level_offset = off;
      layout_q.push_back(r);
      prev = li.size;
    end
    if (levels > 1) begin
      offs[0] = off0;
      m = prev + offs[levels - 2];
      if (m > 64'hFFFF_FFFF) begin
        layout_q.push_back(final_rec(gslc_pkg::ST_OVERFLOW));
        return;
      end
      mip = m;
    end
    r = final_rec(gslc_pkg::ST_OK);
    r.final_tile = tm;
    r.swizzle_out = swz;
    r.image_size = info.size;
    r.chain_size = mip;
    r.base_alignment = info.balign;
    r.row_pitch = info.pitch;
    r.level_count = levels;
    layout_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic surf_t mk_surf(logic [2:0] dim, logic [11:0] fmt, logic [7:0] use_f,
                                    logic [1:0] aa, logic [4:0] tile, logic [13:0] w,
                                    logic [13:0] h, logic [10:0] d, logic [3:0] lvls,
                                    logic [31:0] swz);
    surf_t s;
    s.dim = dim; s.fmt = fmt; s.use_f = use_f; s.aa = aa; s.tile = tile;
    s.w = w; s.h = h; s.d = d; s.lvls = lvls; s.swz = swz;
    s.drain = 0;
    s.ph = 0;
    return s;
  endfunction

  // random size, mostly small with a random bit length
  function automatic int unsigned rnd_size(int unsigned bits);
    if ($urandom_range(9) == 0) return $urandom & ((1 << bits) - 1);
    return $urandom & ((1 << $urandom_range(1, 7)) - 1);
  endfunction

  function automatic surf_t rnd_surf();
    surf_t s;
    logic [4:0] tiles[4];
    logic [11:0] fmts[7];
    tiles = '{gslc_pkg::TILE_DEFAULT, gslc_pkg::TILE_1D_THIN, gslc_pkg::TILE_2D_THIN,
              gslc_pkg::TILE_LIN_SPECIAL};
    fmts = '{FMT_8B, FMT_16B, FMT_32B, FMT_64B, FMT_128B, FMT_BC64, FMT_BC128};
    s = mk_surf($urandom_range(5), {$urandom_range(63), 6'h00} | fmts[$urandom_range(6)],
                $urandom, 0, tiles[$urandom_range(3)], rnd_size(14), rnd_size(14),
                rnd_size(11), $urandom, $urandom);
    s.fmt[5:0] = $urandom_range(3) == 0 ? $urandom_range(63) : fmts[$urandom_range(6)];
    // noise: broken descriptors
    case ($urandom_range(19))
      0: s.aa = $urandom_range(1, 3);
      1: s.dim = $urandom_range(6, 7);
      2: s.tile = $urandom;
      3: s.fmt = $urandom;
      default: ;
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    bit accepted, go;
    int pct;
    accepted = in_tvalid && in_tready;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (accepted) begin
        predict_layout(cur_surf);
        n_sent++;
      end
      if (in_tvalid && !accepted) begin
        // hold the transaction
      end else begin
        go = 0;
        if (pending_q.size() > 0) begin
          pct = (pending_q[0].ph == 1) ? 78 : (pending_q[0].ph == 3) ? 22 : 0;
          go = ($urandom_range(99) >= pct);
          if (pending_q[0].drain && (layout_q.size() > 0 || accepted)) go = 0;
        end
        if (go) begin
          cur_surf = pending_q.pop_front();
          cur_ph <= cur_surf.ph;
          in_tdata <= IN_W'({cur_surf.swz, cur_surf.lvls, cur_surf.d, cur_surf.h,
                             cur_surf.w, cur_surf.tile, cur_surf.aa, cur_surf.use_f,
                             cur_surf.fmt, cur_surf.dim});
        end
        in_tvalid <= go;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  function automatic void cmp_field(string fname, longint unsigned e, longint unsigned a);
    if (e != a) begin
      n_err++;
      if (n_err <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, fname, e, a);
    end
  endfunction

  always @(posedge clk) begin
    gslc_pkg::result_t got, want;
    int pct;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      pct = (cur_ph == 2) ? 78 : (cur_ph == 3) ? 22 : 0;
      out_tready <= ($urandom_range(99) >= pct);
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser[0];
        got.status = out_tdata[2:0];
        got.final_tile = out_tdata[7:3];
        got.swizzle_out = out_tdata[39:8];
        got.image_size = out_tdata[71:40];
        got.chain_size = out_tdata[103:72];
        got.base_alignment = out_tdata[120:104];
        got.row_pitch = out_tdata[136:121];
        got.level_count = out_tdata[140:137];
        got.level_number = out_tdata[144:141];
        got.level_offset = out_tdata[176:145];
        got.last = out_tlast;
        if (layout_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("%0t: unexpected layout transaction", $realtime);
        end else begin
          want = layout_q.pop_front();
          cmp_field("kind", want.kind, got.kind);
          cmp_field("status", want.status, got.status);
          cmp_field("final_tile", want.final_tile, got.final_tile);
          cmp_field("swizzle_out", want.swizzle_out, got.swizzle_out);
          cmp_field("image_size", want.image_size, got.image_size);
          cmp_field("chain_size", want.chain_size, got.chain_size);
          cmp_field("base_alignment", want.base_alignment, got.base_alignment);
          cmp_field("row_pitch", want.row_pitch, got.row_pitch);
          cmp_field("level_count", want.level_count, got.level_count);
          cmp_field("level_number", want.level_number, got.level_number);
          cmp_field("level_offset", want.level_offset, got.level_offset);
          cmp_field("last", want.last, got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    surf_t s;
    // directed: rejections in priority order, each tile and dimension,
    // each element class, demotion of small promoted surfaces, extremes
    pending_q.push_back(mk_surf(gslc_pkg::DIM_2D, FMT_32B, 8'h00, 2'd3,
                                gslc_pkg::TILE_DEFAULT, 64, 64, 1, 4, 0));
    pending_q.push_back(mk_surf(3'd7, FMT_32B, 8'h00, 2'd0, 5'd31, 64, 64, 1, 4, 0));
    pending_q.push_back(mk_surf(3'd6, FMT_32B, 8'h00, 2'd0, gslc_pkg::TILE_DEFAULT,
                                64, 64, 1, 4, 0));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_2D, FMT_ZERO, 8'h00, 2'd0,
                                gslc_pkg::TILE_1D_THICK, 8, 8, 1, 1, 0));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_2D, FMT_HOLE, 8'h00, 2'd0,
                                gslc_pkg::TILE_2D_THIN, 8, 8, 1, 1, 0));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_2D, FMT_TOP, 8'h00, 2'd0,
                                gslc_pkg::TILE_2D_THIN, 8, 8, 1, 1, 0));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_1D, FMT_8B, 8'h00, 2'd0,
                                gslc_pkg::TILE_DEFAULT, 100, 1, 1, 15, 32'hFFFF_FFFF));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_1D, FMT_16B, 8'h04, 2'd0,
                                gslc_pkg::TILE_DEFAULT, 300, 0, 0, 9, 32'h1234_5678));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_2D, FMT_32B, 8'h00, 2'd0,
                                gslc_pkg::TILE_DEFAULT, 4, 4, 1, 3, 0));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_2D, FMT_32B, 8'h02, 2'd0,
                                gslc_pkg::TILE_DEFAULT, 512, 256, 1, 14, 32'h00AB_0123));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_3D, FMT_64B, 8'h00, 2'd0,
                                gslc_pkg::TILE_DEFAULT, 64, 64, 64, 8, 32'h0000_0040));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_3D, FMT_64B, 8'h00, 2'd0,
                                gslc_pkg::TILE_DEFAULT, 2, 2, 2, 2, 0));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_CUBE, FMT_128B, 8'h02, 2'd0,
                                gslc_pkg::TILE_2D_THIN, 128, 128, 0, 8, 32'hFF00_0100));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_1D_ARRAY, FMT_BC64, 8'h00, 2'd0,
                                gslc_pkg::TILE_1D_THIN, 256, 0, 20, 6, 0));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_2D_ARRAY, FMT_BC128, 8'h00, 2'd0,
                                gslc_pkg::TILE_LIN_SPECIAL, 1000, 600, 3, 11,
                                32'hDEAD_BEEF));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_2D, FMT_BC64, 8'h00, 2'd0,
                                gslc_pkg::TILE_DEFAULT, 16383, 16383, 1, 15,
                                32'h0000_FFFF));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_3D, FMT_128B, 8'hFF, 2'd0,
                                gslc_pkg::TILE_2D_THIN, 16383, 16383, 2047, 15,
                                32'hFFFF_FFFF));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_CUBE, FMT_128B, 8'h00, 2'd0,
                                gslc_pkg::TILE_LIN_SPECIAL, 16383, 16383, 2047, 15, 0));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_3D, FMT_32B, 8'h00, 2'd0,
                                gslc_pkg::TILE_DEFAULT, 4096, 4096, 64, 13,
                                32'h0000_8000));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_2D_ARRAY, FMT_32B, 8'h00, 2'd0,
                                gslc_pkg::TILE_2D_THIN, 8192, 8192, 15, 14,
                                32'h0000_FFFF));
    pending_q.push_back(mk_surf(gslc_pkg::DIM_1D, FMT_8B, 8'h00, 2'd0,
                                gslc_pkg::TILE_LIN_SPECIAL, 0, 0, 0, 0, 0));
    for (int i = 0; i < N_RANDOM; i++) begin
      s = rnd_surf();
      s.ph = i * 4 / N_RANDOM;
      s.drain = (i % 90 == 45);
      pending_q.push_back(s);
    end
    n_total = pending_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (n_sent == n_total && layout_q.size() == 0);
    repeat (100) @(posedge clk);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
